/* sv/tspa_pkg.sv */
// ----------------------------------------------------------------------------
// tspa_pkg
// Shared types and codes for the tile slot pool allocator.
// ----------------------------------------------------------------------------
package tspa_pkg;

  typedef enum logic [1:0] {
    KIND_ACQ   = 2'd0,
    KIND_REL   = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_INIT  = 2'd3
  } kind_t;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_EXHAUST = 2'd1;
  localparam logic [1:0] STAT_NOT_USE = 2'd2;

  localparam logic [1:0] CFG_ITEMS = 2'd0;
  localparam logic [1:0] CFG_FMT   = 2'd1;
  localparam logic [1:0] CFG_TILE  = 2'd2;

  localparam int SLOT_W   = 10;
  localparam int REGION_W = 15;
  localparam int COUNT_W  = 11;
  localparam int DIM_W    = 11;
  localparam int SIDE_W   = 6;
  localparam logic [REGION_W-1:0] REGION_MAX = 15'h7FFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQRT,
    S_FILL,
    S_FL_RD,
    S_FL_WR,
    S_POP_RD,
    S_POP_WAIT,
    S_DIV,
    S_MUL_X,
    S_MUL_Y,
    S_REL_RD,
    S_REL_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                ok;
    logic [SLOT_W-1:0]   granted_slot;
    logic [REGION_W-1:0] region_x;
    logic [REGION_W-1:0] region_y;
    logic [1:0]          status;
    logic [COUNT_W-1:0]  free_count;
  } res_t;

  typedef struct packed {
    logic [COUNT_W-1:0] pool_items_setting;
    logic               uncompressed_format;
    logic [DIM_W-1:0]   tile_dim;
  } cfg_t;

endpackage

/* sv/tspa_div.sv */
// ----------------------------------------------------------------------------
// tspa_div
// Restoring divider, one quotient bit per cycle: slot / grid side.
// ----------------------------------------------------------------------------
module tspa_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tspa_pkg::SLOT_W-1:0]   dividend,
  input  logic [tspa_pkg::SIDE_W-1:0]   divisor,
  output logic                          done,
  output logic [tspa_pkg::SLOT_W-1:0]   quot,
  output logic [tspa_pkg::SIDE_W-1:0]   rem
);

  localparam int CNT_W = $clog2(tspa_pkg::SLOT_W + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [tspa_pkg::SLOT_W-1:0] q_r, q_nxt;
  logic [tspa_pkg::SIDE_W-1:0] rem_r, rem_nxt;
  logic [tspa_pkg::SIDE_W:0]   rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r, q_r[tspa_pkg::SLOT_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt = tspa_pkg::SIDE_W'(rem_sh - {1'b0, divisor});
        q_nxt   = {q_r[tspa_pkg::SLOT_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[tspa_pkg::SIDE_W-1:0];
        q_nxt   = {q_r[tspa_pkg::SLOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(tspa_pkg::SLOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

/* sv/tspa_ctrl.sv */
// ----------------------------------------------------------------------------
// tspa_ctrl
// Sequencer with free stack, quarantine list and in-use flag memories.
// ----------------------------------------------------------------------------
module tspa_ctrl #(
  parameter int SLOT_CAP = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tspa_pkg::cfg_t              cfg,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  tspa_pkg::kind_t             req_kind,
  input  logic [tspa_pkg::SLOT_W-1:0] req_slot,
  output logic                        res_valid,
  input  logic                        res_ready,
  output tspa_pkg::res_t              res
);

  localparam int AW = (SLOT_CAP > 1) ? $clog2(SLOT_CAP) : 1;
  localparam int CW = $clog2(SLOT_CAP + 1);

  tspa_pkg::state_t state_r, state_nxt;
  tspa_pkg::kind_t  kind_r, kind_nxt;
  logic [tspa_pkg::SLOT_W-1:0]   slot_r, slot_nxt;
  logic [CW-1:0] free_top_r, free_top_nxt;
  logic [CW-1:0] q_cnt_r, q_cnt_nxt;
  logic [CW-1:0] active_r, active_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [tspa_pkg::SIDE_W-1:0]   grid_r, grid_nxt;
  logic [11:0]                   sq_r, sq_nxt;
  logic [tspa_pkg::DIM_W-1:0]    tile_r, tile_nxt;
  logic                          ok_r, ok_nxt;
  logic [1:0]                    stat_r, stat_nxt;
  logic [tspa_pkg::SLOT_W-1:0]   gnt_r, gnt_nxt;
  logic [tspa_pkg::REGION_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt;

  logic [tspa_pkg::SLOT_W-1:0] free_mem [SLOT_CAP];
  logic [tspa_pkg::SLOT_W-1:0] q_mem [SLOT_CAP];
  logic                        use_mem [SLOT_CAP];

  logic                        free_we, q_we, use_we, use_wd;
  logic [AW-1:0]               free_wa, free_ra, q_wa, q_ra, use_wa, use_ra;
  logic [tspa_pkg::SLOT_W-1:0] free_wd, q_wd, free_rd_r, q_rd_r;
  logic                        use_rd_r;

  logic                        div_start, div_done;
  logic [tspa_pkg::SLOT_W-1:0] div_q;
  logic [tspa_pkg::SIDE_W-1:0] div_r;

  logic [tspa_pkg::SLOT_W-1:0] mul_a;
  logic [tspa_pkg::SLOT_W+tspa_pkg::DIM_W-1:0] prod;
  logic [tspa_pkg::REGION_W-1:0] prod_sat;
  logic [tspa_pkg::COUNT_W-1:0]  n_raw;

  tspa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (gnt_r),
    .divisor  (grid_r),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign prod     = mul_a * tile_r;
  assign prod_sat = (prod > {{(tspa_pkg::SLOT_W+tspa_pkg::DIM_W-tspa_pkg::REGION_W){1'b0}},
                             tspa_pkg::REGION_MAX})
                    ? tspa_pkg::REGION_MAX : prod[tspa_pkg::REGION_W-1:0];
  assign n_raw    = cfg.uncompressed_format ? (cfg.pool_items_setting >> 2)
                                            : cfg.pool_items_setting;

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    slot_nxt     = slot_r;
    free_top_nxt = free_top_r;
    q_cnt_nxt    = q_cnt_r;
    active_nxt   = active_r;
    idx_nxt      = idx_r;
    grid_nxt     = grid_r;
    sq_nxt       = sq_r;
    tile_nxt     = tile_r;
    ok_nxt       = ok_r;
    stat_nxt     = stat_r;
    gnt_nxt      = gnt_r;
    rx_nxt       = rx_r;
    ry_nxt       = ry_r;
    free_we      = 1'b0;
    free_wa      = AW'(free_top_r);
    free_wd      = q_rd_r;
    free_ra      = AW'(free_top_r - 1'b1);
    q_we         = 1'b0;
    q_wa         = AW'(q_cnt_r);
    q_wd         = slot_r;
    q_ra         = AW'(idx_r);
    use_we       = 1'b0;
    use_wa       = AW'(slot_r);
    use_wd       = 1'b0;
    use_ra       = AW'(slot_r);
    div_start    = 1'b0;
    mul_a        = div_q;
    case (state_r)
      tspa_pkg::S_IDLE: begin
        if (req_valid) begin
          kind_nxt = req_kind;
          slot_nxt = req_slot;
          ok_nxt   = 1'b0;
          stat_nxt = tspa_pkg::STAT_OK;
          gnt_nxt  = '0;
          rx_nxt   = '0;
          ry_nxt   = '0;
          idx_nxt  = '0;
          case (req_kind)
            tspa_pkg::KIND_ACQ: begin
              state_nxt = (free_top_r == '0) ? tspa_pkg::S_FL_RD : tspa_pkg::S_POP_RD;
            end
            tspa_pkg::KIND_REL: begin
              state_nxt = tspa_pkg::S_REL_RD;
            end
            tspa_pkg::KIND_FLUSH: begin
              state_nxt = tspa_pkg::S_FL_RD;
            end
            default: begin
              active_nxt   = (n_raw > tspa_pkg::COUNT_W'(SLOT_CAP)) ? CW'(SLOT_CAP) : CW'(n_raw);
              tile_nxt     = cfg.tile_dim;
              free_top_nxt = '0;
              q_cnt_nxt    = '0;
              grid_nxt     = '0;
              sq_nxt       = 12'd1;
              state_nxt    = tspa_pkg::S_SQRT;
            end
          endcase
        end
      end
      tspa_pkg::S_SQRT: begin
        if (sq_r <= 12'(active_r)) begin
          grid_nxt = grid_r + 1'b1;
          sq_nxt   = sq_r + {5'd0, grid_r, 1'b0} + 12'd3;
        end else begin
          state_nxt = tspa_pkg::S_FILL;
        end
      end
      tspa_pkg::S_FILL: begin
        if (idx_r == active_r) begin
          free_top_nxt = active_r;
          ok_nxt       = 1'b1;
          state_nxt    = tspa_pkg::S_DONE;
        end else begin
          free_we = 1'b1;
          free_wa = AW'(idx_r);
          free_wd = tspa_pkg::SLOT_W'(active_r - idx_r - 1'b1);
          use_we  = 1'b1;
          use_wa  = AW'(idx_r);
          use_wd  = 1'b0;
          idx_nxt = idx_r + 1'b1;
        end
      end
      tspa_pkg::S_FL_RD: begin
        if (idx_r == q_cnt_r) begin
          q_cnt_nxt = '0;
          if (kind_r == tspa_pkg::KIND_ACQ) begin
            if (free_top_r == '0) begin
              stat_nxt  = tspa_pkg::STAT_EXHAUST;
              state_nxt = tspa_pkg::S_DONE;
            end else begin
              state_nxt = tspa_pkg::S_POP_RD;
            end
          end else begin
            ok_nxt    = 1'b1;
            state_nxt = tspa_pkg::S_DONE;
          end
        end else begin
          state_nxt = tspa_pkg::S_FL_WR;
        end
      end
      tspa_pkg::S_FL_WR: begin
        if (free_top_r < CW'(SLOT_CAP)) begin
          free_we      = 1'b1;
          free_top_nxt = free_top_r + 1'b1;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = tspa_pkg::S_FL_RD;
      end
      tspa_pkg::S_POP_RD: begin
        state_nxt = tspa_pkg::S_POP_WAIT;
      end
      tspa_pkg::S_POP_WAIT: begin
        gnt_nxt      = free_rd_r;
        free_top_nxt = free_top_r - 1'b1;
        use_we       = 1'b1;
        use_wa       = AW'(free_rd_r);
        use_wd       = 1'b1;
        ok_nxt       = 1'b1;
        idx_nxt      = '0;
        if (grid_r == '0) begin
          state_nxt = tspa_pkg::S_DONE;
        end else begin
          state_nxt = tspa_pkg::S_DIV;
        end
      end
      tspa_pkg::S_DIV: begin
        if (idx_r == '0) begin
          div_start = 1'b1;
          idx_nxt   = CW'(1);
        end else if (div_done) begin
          state_nxt = tspa_pkg::S_MUL_X;
        end
      end
      tspa_pkg::S_MUL_X: begin
        mul_a     = div_q;
        rx_nxt    = prod_sat;
        state_nxt = tspa_pkg::S_MUL_Y;
      end
      tspa_pkg::S_MUL_Y: begin
        mul_a     = tspa_pkg::SLOT_W'(div_r);
        ry_nxt    = prod_sat;
        state_nxt = tspa_pkg::S_DONE;
      end
      tspa_pkg::S_REL_RD: begin
        state_nxt = tspa_pkg::S_REL_CHK;
      end
      tspa_pkg::S_REL_CHK: begin
        if ((CW+1)'(slot_r) < (CW+1)'(active_r) && use_rd_r &&
            q_cnt_r < CW'(SLOT_CAP)) begin
          use_we    = 1'b1;
          use_wd    = 1'b0;
          q_we      = 1'b1;
          q_cnt_nxt = q_cnt_r + 1'b1;
          ok_nxt    = 1'b1;
        end else begin
          stat_nxt = tspa_pkg::STAT_NOT_USE;
        end
        state_nxt = tspa_pkg::S_DONE;
      end
      tspa_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = tspa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tspa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tspa_pkg::S_IDLE;
      free_top_r <= '0;
      q_cnt_r    <= '0;
      active_r   <= '0;
      grid_r     <= '0;
      tile_r     <= '0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      free_top_r <= free_top_nxt;
      q_cnt_r    <= q_cnt_nxt;
      active_r   <= active_nxt;
      grid_r     <= grid_nxt;
      tile_r     <= tile_nxt;
      idx_r      <= idx_nxt;
    end
    kind_r <= kind_nxt;
    slot_r <= slot_nxt;
    sq_r   <= sq_nxt;
    ok_r   <= ok_nxt;
    stat_r <= stat_nxt;
    gnt_r  <= gnt_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd_r <= free_mem[free_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd_r <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (use_we) use_mem[use_wa] <= use_wd;
    use_rd_r <= use_mem[use_ra];
  end

  assign req_ready        = (state_r == tspa_pkg::S_IDLE);
  assign res_valid        = (state_r == tspa_pkg::S_DONE);
  assign res.ok           = ok_r;
  assign res.granted_slot = gnt_r;
  assign res.region_x     = rx_r;
  assign res.region_y     = ry_r;
  assign res.status       = stat_r;
  assign res.free_count   = tspa_pkg::COUNT_W'(free_top_r);

  a_top_cap: assert property (@(posedge clk) disable iff (!rst_n)
    free_top_r <= CW'(SLOT_CAP))
    else $error("free stack above capacity");

  // entries are counted twice while the quarantine drains
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != tspa_pkg::S_FL_RD && state_r != tspa_pkg::S_FL_WR) |->
    (((CW+1)'(free_top_r) + (CW+1)'(q_cnt_r)) <= (CW+1)'(active_r)))
    else $error("free plus quarantine exceeds active slots");

  a_exhaust: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && stat_r == tspa_pkg::STAT_EXHAUST) |-> (free_top_r == '0 && !ok_r))
    else $error("exhaustion reported with free slots");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(gnt_r) && $stable(free_top_r)))
    else $error("result changed while stalled");

endmodule

/* sv/tile_slot_pool_allocator_top.sv */
// ----------------------------------------------------------------------------
// tile_slot_pool_allocator_top
// LIFO tile slot allocator with quarantine, on a square atlas grid.
// ----------------------------------------------------------------------------
// Input channel in_*: one beat per command. in_tuser carries the kind
// (acquire, release, flush, init), in_tdata the slot to release.
// Output channel out_*: one result beat per command.
// Config port cfg_*: index 0 slot count, 1 uncompressed format, 2 tile edge;
// the values are picked up only by an init command.
// Per command: acquire pops the free stack, first draining the quarantine when
// that stack is empty, then runs the 10-step divider and the two multiply steps
// of the region origin if the grid is not empty; release checks and quarantines
// one slot; flush drains the quarantine; init runs the square root search and
// the free stack fill for n slots. One command is in flight at a time.
// Results sit in an output register; the sequencer can start the next command
// while that beat waits, and holds its own result until the register frees.
// Reset empties the pool; acquire before init reports exhaustion.
// ----------------------------------------------------------------------------
module tile_slot_pool_allocator_top #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] slot_id
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // ok, granted_slot, region_x, region_y, status, free_count
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [10:0] cfg_wdata
);

  localparam int SLOT_CAP = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;

  tspa_pkg::cfg_t cfg_r;
  tspa_pkg::res_t res, out_r;
  logic           res_valid, res_ready, out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        tspa_pkg::CFG_ITEMS: cfg_r.pool_items_setting  <= cfg_wdata;
        tspa_pkg::CFG_FMT:   cfg_r.uncompressed_format <= cfg_wdata[0];
        tspa_pkg::CFG_TILE:  cfg_r.tile_dim            <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  tspa_ctrl #(.SLOT_CAP(SLOT_CAP)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_kind  (tspa_pkg::kind_t'(in_tuser)),
    .req_slot  (in_tdata[9:0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.free_count, out_r.status, out_r.region_y,
                       out_r.region_x, out_r.granted_slot, out_r.ok};

endmodule

/* tb/tspa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspa_checker
// Watches the command and result streams of the tile slot pool allocator. It
// keeps its own copy of the pool (free stack, in-use flags, quarantine, grid)
// and computes each result in order. Every result beat is compared field by
// field with the oldest computed result.
// ----------------------------------------------------------------------------
module tspa_checker #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [10:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          result_count
);

  localparam int CAP = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;

  tspa_pkg::cfg_t regs;
  logic [9:0]     free_stack [CAP];
  int             free_top;
  bit             in_use [1024];
  logic [9:0]     quar [CAP];
  int             quar_count;
  int             grid_side;
  int             active_slots;
  int             dim_latched;
  tspa_pkg::res_t expected_q[$];

  function automatic int isqrt(int n);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  function automatic int sat15(int v);
    return (v > 32767) ? 32767 : v;
  endfunction

  task automatic drain_quarantine();
    for (int i = 0; i < quar_count; i++) begin
      if (free_top < CAP) begin
        free_stack[free_top] = quar[i];
        free_top++;
      end
    end
    quar_count = 0;
  endtask

  task automatic apply_command(input tspa_pkg::kind_t kind, input int slot);
    tspa_pkg::res_t r;
    int             n;
    r = '0;
    case (kind)
      tspa_pkg::KIND_ACQ: begin
        if (free_top == 0) drain_quarantine();
        if (free_top == 0) begin
          r.status = tspa_pkg::STAT_EXHAUST;
        end else begin
          free_top--;
          r.granted_slot = free_stack[free_top];
          in_use[r.granted_slot] = 1;
          if (grid_side != 0) begin
            r.region_x = 15'(sat15((int'(r.granted_slot) / grid_side) * dim_latched));
            r.region_y = 15'(sat15((int'(r.granted_slot) % grid_side) * dim_latched));
          end
          r.ok = 1;
        end
      end
      tspa_pkg::KIND_REL: begin
        if (slot < active_slots && in_use[slot] && quar_count < CAP) begin
          in_use[slot] = 0;
          quar[quar_count] = 10'(slot);
          quar_count++;
          r.ok = 1;
        end else begin
          r.status = tspa_pkg::STAT_NOT_USE;
        end
      end
      tspa_pkg::KIND_FLUSH: begin
        drain_quarantine();
        r.ok = 1;
      end
      default: begin
        n = int'(regs.pool_items_setting);
        if (regs.uncompressed_format) n = n / 4;
        if (n > CAP) n = CAP;
        for (int i = 0; i < 1024; i++) in_use[i] = 0;
        quar_count = 0;
        active_slots = n;
        dim_latched = int'(regs.tile_dim);
        grid_side = isqrt(n);
        for (int i = 0; i < n; i++) free_stack[i] = 10'(n - 1 - i);
        free_top = n;
        r.ok = 1;
      end
    endcase
    r.free_count = 11'(free_top);
    expected_q.push_back(r);
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    tspa_pkg::res_t got;
    tspa_pkg::res_t exp_r;
    if (!rst_n) begin
      regs <= '0;
      free_top = 0;
      quar_count = 0;
      grid_side = 0;
      active_slots = 0;
      dim_latched = 0;
      for (int i = 0; i < 1024; i++) in_use[i] = 0;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          tspa_pkg::CFG_ITEMS: regs.pool_items_setting <= cfg_wdata;
          tspa_pkg::CFG_FMT:   regs.uncompressed_format <= cfg_wdata[0];
          tspa_pkg::CFG_TILE:  regs.tile_dim <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        apply_command(tspa_pkg::kind_t'(in_tuser), int'(in_tdata[9:0]));
      if (out_tvalid && out_tready) begin
        got.ok           = out_tdata[0];
        got.granted_slot = out_tdata[10:1];
        got.region_x     = out_tdata[25:11];
        got.region_y     = out_tdata[40:26];
        got.status       = out_tdata[42:41];
        got.free_count   = out_tdata[53:43];
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected ok=%0d slot=%0d x=%0d y=%0d st=%0d free=%0d",
                     $time, exp_r.ok, exp_r.granted_slot, exp_r.region_x,
                     exp_r.region_y, exp_r.status, exp_r.free_count);
            $display("%0t:          actual ok=%0d slot=%0d x=%0d y=%0d st=%0d free=%0d",
                     $time, got.ok, got.granted_slot, got.region_x, got.region_y,
                     got.status, got.free_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pool commands into the tile slot pool allocator across several
// configurations (tiny to full pools, both formats, extreme tile sizes) with
// random idle and back-pressure; the checker computes and compares results.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [10:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          result_count;
  int          idle_cycles;
  bit          calm;
  int          configs_run;

  tile_slot_pool_allocator_top uut (.*);

  tspa_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("FAIL tile_slot_pool_allocator_top");
      $finish;
    end
  end

  task automatic send_cmd(input tspa_pkg::kind_t kind, input int slot);
    while (!calm && $urandom_range(99) < 10) @(posedge clk);
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {6'($urandom_range(63)), 10'(slot)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic set_config(input int count, input bit fmt, input int dim);
    wait_idle();
    cfg_we <= 1; cfg_addr <= tspa_pkg::CFG_ITEMS; cfg_wdata <= 11'(count);
    @(posedge clk);
    cfg_addr <= tspa_pkg::CFG_FMT; cfg_wdata <= 11'(fmt);
    @(posedge clk);
    cfg_addr <= tspa_pkg::CFG_TILE; cfg_wdata <= 11'(dim);
    @(posedge clk);
    cfg_we <= 0;
    configs_run++;
  endtask

  // mostly acquire and release of random slots below slots, some flush, rare noise
  task automatic random_phase(input int items, input int slots);
    logic [9:0] held[$];
    int pick;
    int r;
    send_cmd(tspa_pkg::KIND_INIT, 0);
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        send_cmd(tspa_pkg::KIND_ACQ, $urandom);
        held.push_back(10'(k));
      end else if (r < 80 && held.size() > 0) begin
        pick = $urandom_range(slots > 0 ? slots - 1 : 0);
        send_cmd(tspa_pkg::KIND_REL, pick);
      end else if (r < 90) begin
        send_cmd(tspa_pkg::KIND_FLUSH, $urandom);
      end else if (r < 98) begin
        send_cmd(tspa_pkg::KIND_REL, $urandom);
      end else begin
        send_cmd(tspa_pkg::KIND_INIT, $urandom);
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = tspa_pkg::KIND_ACQ;
    cfg_we = 0;
    cfg_addr = 0;
    cfg_wdata = 0;
    calm = 0;
    configs_run = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: before init, tiny pool, exhaustion, bad releases
    send_cmd(tspa_pkg::KIND_ACQ, 0);
    send_cmd(tspa_pkg::KIND_REL, 1023);
    send_cmd(tspa_pkg::KIND_FLUSH, 0);
    send_cmd(tspa_pkg::KIND_INIT, 0);
    send_cmd(tspa_pkg::KIND_ACQ, 0);
    set_config(4, 0, 1024);
    send_cmd(tspa_pkg::KIND_INIT, 0);
    repeat (4) send_cmd(tspa_pkg::KIND_ACQ, 0);
    send_cmd(tspa_pkg::KIND_ACQ, 0);
    send_cmd(tspa_pkg::KIND_REL, 2);
    send_cmd(tspa_pkg::KIND_REL, 2);
    send_cmd(tspa_pkg::KIND_REL, 0);
    send_cmd(tspa_pkg::KIND_REL, 5);
    send_cmd(tspa_pkg::KIND_ACQ, 0);
    send_cmd(tspa_pkg::KIND_ACQ, 0);
    send_cmd(tspa_pkg::KIND_REL, 3);
    send_cmd(tspa_pkg::KIND_FLUSH, 0);
    send_cmd(tspa_pkg::KIND_ACQ, 0);
    set_config(2047, 1, 2047);
    send_cmd(tspa_pkg::KIND_INIT, 0);
    send_cmd(tspa_pkg::KIND_ACQ, 0);
    set_config(2047, 0, 0);
    send_cmd(tspa_pkg::KIND_INIT, 0);
    send_cmd(tspa_pkg::KIND_ACQ, 0);
    send_cmd(tspa_pkg::KIND_REL, 1023);

    set_config(9, 0, 37);
    random_phase(400, 9);
    calm = 1;
    set_config(64, 1, 300);
    random_phase(300, 16);
    calm = 0;
    set_config(30, 0, 1023);
    random_phase(400, 30);
    set_config(1024, 0, 64);
    random_phase(250, 1024);
    set_config(3, 1, 5);
    random_phase(100, 1);
    set_config(50, 0, 2047);
    random_phase(300, 50);

    wait_idle();
    $display("Covered %0d configurations and %0d result beats, with back-pressure.",
             configs_run, result_count);
    if (fail_count == 0) begin
      $display("PASS tile_slot_pool_allocator_top");
    end else begin
      $display("FAIL tile_slot_pool_allocator_top");
    end
    $finish;
  end

endmodule
